@@ sv/smtp_dot_stuffer_top_assert.svh @@
// Assertion macros for the dot stuffer checker.
`ifndef SMTP_DOT_STUFFER_TOP_ASSERT_SVH
`define SMTP_DOT_STUFFER_TOP_ASSERT_SVH

// Checks that a condition leads to a consequence on the next clock edge, outside reset.
`define SMTP_DS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("smtp_ds checker: property failed");

// The same check without a reset guard, for properties about reset itself.
`define SMTP_DS_ASSERT_RST(label, pre, post) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("smtp_ds checker: reset property failed");

`endif

@@ sv/smtp_ds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package smtp_ds_pkg;

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_DOT = 8'h2E;

    localparam int MAX_RUN = 4;
    localparam int RUN_CNT_W = 3;

    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    cnt;
        logic                    crlf;
    } t_run;

    function automatic logic [7:0] find_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = BYTE_CR;
            2'd1:    v = BYTE_LF;
            default: v = BYTE_DOT;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = BYTE_CR;
            2'd1:    v = BYTE_LF;
            default: v = BYTE_DOT;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/smtp_dot_stuffer_top.sv @@
// Channel  Direction  tdata (low bit up)  tuser (low bit up)  tlast
// s_axis   in         data_byte [7:0]     end_of_buffer       -
// m_axis   out        out_byte [7:0]      ends_with_crlf      last_of_run
//
// One input word is taken per cycle while the run queue has room.
// Each input word yields zero to four output words, sent one per cycle by the serialiser while the output is ready.
// A run passes through the run queue and then the serialiser's run register on its way to the output.
// Reset is synchronous and active low; it empties the queue and clears the match state.
// Either side may stall; the run queue lets input carry on while output waits.
`timescale 1ns / 1ps
`default_nettype none
module smtp_dot_stuffer_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // data_byte
    input  wire logic       s_axis_tuser,  // end_of_buffer
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // out_byte
    output logic            m_axis_tlast,
    output logic            m_axis_tuser   // ends_with_crlf
);
    import smtp_ds_pkg::*;

    t_run front_run;
    t_run queue_run;
    logic push;
    logic full;
    logic pop;
    logic queue_valid;

    smtp_ds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_eob   (s_axis_tuser),
        .i_full  (full),
        .o_push  (push),
        .o_run   (front_run)
    );

    smtp_ds_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (front_run),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_run   (queue_run)
    );

    smtp_ds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_run   (queue_run),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_crlf  (m_axis_tuser)
    );

endmodule
`default_nettype wire

@@ sv/smtp_ds_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smtp_ds_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data,
    input  wire logic              i_eob,
    input  wire logic              i_full,
    output logic                   o_push,
    output smtp_ds_pkg::t_run      o_run
);
    import smtp_ds_pkg::*;

    logic [1:0] r_ml, n_ml;
    logic [1:0] r_as, n_as;
    logic       r_crlf, n_crlf;

    logic       accept;
    logic       match;
    logic       mism;
    logic [2:0] ml1;
    logic [1:0] as1;
    logic [1:0] ml2;
    logic [1:0] as2;
    logic       full_match;
    logic [RUN_CNT_W-1:0] n;
    t_run       run;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        match = (i_data == find_byte(r_ml));
        mism  = !match && (r_ml != 2'd0);
        if (match) begin
            ml1    = {1'b0, r_ml} + 3'd1;
            n_crlf = (r_ml == 2'd1);
        end else if (mism) begin
            ml1    = (i_data == BYTE_CR) ? 3'd1 : 3'd0;
            n_crlf = 1'b0;
        end else begin
            ml1    = 3'd0;
            n_crlf = r_crlf;
        end
        as1        = mism ? 2'd0 : r_as;
        full_match = (ml1 == 3'd3);
        ml2        = full_match ? 2'd0 : ml1[1:0];
        as2        = full_match ? 2'd0 : as1;

        run.bytes = '0;
        n = '0;
        for (int k = 0; k < 3; k++) begin
            if (mism && (2'(k) >= r_as) && (2'(k) < r_ml)) begin
                run.bytes[n[1:0]] = find_byte(2'(k));
                n = n + 1'b1;
            end
        end
        if (full_match) begin
            for (int k = 0; k < MAX_RUN; k++) begin
                if (2'(k) >= as1) begin
                    run.bytes[n[1:0]] = repl_byte(2'(k));
                    n = n + 1'b1;
                end
            end
        end else if (ml1 == 3'd0) begin
            run.bytes[n[1:0]] = i_data;
            n = n + 1'b1;
        end
        if (i_eob) begin
            for (int k = 0; k < 3; k++) begin
                if ((2'(k) >= as2) && (2'(k) < ml2)) begin
                    run.bytes[n[1:0]] = find_byte(2'(k));
                    n = n + 1'b1;
                end
            end
        end
        n_ml     = ml2;
        n_as     = i_eob ? ml2 : as2;
        run.cnt  = n;
        run.crlf = n_crlf;
    end

    assign o_run  = run;
    assign o_push = accept && (n != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ml   <= 2'd0;
            r_as   <= 2'd0;
            r_crlf <= 1'b0;
        end else if (accept) begin
            r_ml   <= n_ml;
            r_as   <= n_as;
            r_crlf <= n_crlf;
        end
    end

endmodule
`default_nettype wire

@@ sv/smtp_ds_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smtp_ds_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  smtp_ds_pkg::t_run      i_run,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output smtp_ds_pkg::t_run      o_run
);
    import smtp_ds_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_run             mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_run   = mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/smtp_ds_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module smtp_ds_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  smtp_ds_pkg::t_run      i_run,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_data,
    output logic                   o_last,
    output logic                   o_crlf
);
    import smtp_ds_pkg::*;

    t_run       r_run;
    logic       r_valid;
    logic [1:0] r_idx;
    logic       last;
    logic       done;

    assign last    = ({1'b0, r_idx} == (r_run.cnt - 1'b1));
    assign done    = r_valid && i_ready && last;
    assign o_pop   = i_valid && (!r_valid || done);
    assign o_valid = r_valid;
    assign o_data  = r_run.bytes[r_idx];
    assign o_last  = last;
    assign o_crlf  = r_run.crlf;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_run <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ sv/smtp_ds_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "smtp_dot_stuffer_top_assert.svh"
module smtp_ds_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);

    // A waiting output word stays offered.
    `SMTP_DS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A waiting output word keeps its contents.
    `SMTP_DS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // The words of one run follow without a gap and share the trailing CR LF flag.
    `SMTP_DS_ASSERT_NEXT(a_run_flag, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
        m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser)))

    // Nothing is offered straight after reset.
    `SMTP_DS_ASSERT_RST(a_reset_idle, !i_rst_n, !m_axis_tvalid)

endmodule

bind smtp_dot_stuffer_top smtp_ds_checker u_smtp_ds_checker (.*);
`default_nettype wire
